[src/sgi_pkg.sv]
`timescale 1ns / 1ps
package sgi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MARGIN_W        = 17;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1);

endpackage

[src/sgi_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage, magnitudes in, magnitude out
module sgi_div #(
  parameter int NW    = 49,
  parameter int DW    = 33,
  parameter int LANES = 1,
  parameter int SBW   = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  num [LANES],
  input  logic [DW-1:0]  den [LANES],
  input  logic           neg [LANES],
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [NW-1:0]  quo [LANES],
  output logic           out_neg [LANES],
  output logic [SBW-1:0] out_sb
);

  logic [NW-1:0]  r_nq [1:NW][LANES];
  logic [DW-1:0]  r_rm [1:NW][LANES];
  logic [DW-1:0]  r_dv [1:NW][LANES];
  logic           r_ng [1:NW][LANES];
  logic [SBW-1:0] r_sb [1:NW];
  logic           r_vl [1:NW];

  logic [NW-1:0]  s_nq [0:NW-1][LANES];
  logic [DW-1:0]  s_rm [0:NW-1][LANES];
  logic [DW-1:0]  s_dv [0:NW-1][LANES];
  logic           s_ng [0:NW-1][LANES];
  logic [SBW-1:0] s_sb [0:NW-1];
  logic           s_vl [0:NW-1];

  logic [NW-1:0]  n_nq [0:NW-1][LANES];
  logic [DW-1:0]  n_rm [0:NW-1][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s_nq[0][l] = num[l];
      s_rm[0][l] = '0;
      s_dv[0][l] = den[l];
      s_ng[0][l] = neg[l];
    end
    s_sb[0] = in_sb;
    s_vl[0] = in_valid;
    for (int k = 1; k < NW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        s_nq[k][l] = r_nq[k][l];
        s_rm[k][l] = r_rm[k][l];
        s_dv[k][l] = r_dv[k][l];
        s_ng[k][l] = r_ng[k][l];
      end
      s_sb[k] = r_sb[k];
      s_vl[k] = r_vl[k];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    trial = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int k = 0; k < NW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {s_rm[k][l], s_nq[k][l][NW-1]};
        diff  = trial - {1'b0, s_dv[k][l]};
        ge    = trial >= {1'b0, s_dv[k][l]};
        n_rm[k][l] = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_nq[k][l] = {s_nq[k][l][NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NW; k++) r_vl[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NW; k++) r_vl[k+1] <= s_vl[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        for (int l = 0; l < LANES; l++) begin
          r_nq[k+1][l] <= n_nq[k][l];
          r_rm[k+1][l] <= n_rm[k][l];
          r_dv[k+1][l] <= s_dv[k][l];
          r_ng[k+1][l] <= s_ng[k][l];
        end
        r_sb[k+1] <= s_sb[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l]     = r_nq[NW][l];
      out_neg[l] = r_ng[NW][l];
    end
  end

  assign out_sb    = r_sb[NW];
  assign out_valid = r_vl[NW];

endmodule

[src/segment_intersection.sv]
`timescale 1ns / 1ps
// Segment pair intersection, signed fixed point (Q16.16 at default widths).
// Input channel in_valid/in_stall carries one word: two segments a and b.
// Output channel out_valid/out_stall returns one word per input word: hit
// and the crossing point, or a zero point when the segments do not cross.
// Throughput: one word per cycle unless the receiver stalls. The pipeline
// is a slope divider, an intercept section, a crossing divider and a check
// section; each divider resolves one quotient bit per stage over
// COORD_WIDTH+FRAC_BITS+1 stages.
// cfg_wen/cfg_wdata write the tolerance margin; write it only while the block
// is empty. Reset empties the pipeline and sets the margin to 1.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
module segment_intersection #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sgi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] a_x0,
  input  logic signed [COORD_WIDTH-1:0] a_y0,
  input  logic signed [COORD_WIDTH-1:0] a_x1,
  input  logic signed [COORD_WIDTH-1:0] a_y1,
  input  logic signed [COORD_WIDTH-1:0] b_x0,
  input  logic signed [COORD_WIDTH-1:0] b_y0,
  input  logic signed [COORD_WIDTH-1:0] b_x1,
  input  logic signed [COORD_WIDTH-1:0] b_y1,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] cross_x,
  output logic signed [COORD_WIDTH-1:0] cross_y,
  input  logic                          cfg_wen,
  input  logic [sgi_pkg::MARGIN_W-1:0]  cfg_wdata
);
  import sgi_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NW   = W + 1 + F;
  localparam int DW   = W + 1;
  localparam int SATW = (NW + 1 > 2 * W + 2) ? NW + 1 : 2 * W + 2;
  localparam int CMPW = W + MARGIN_W + 2;
  localparam int SB1  = 8 * W + 4;
  localparam int SB2  = 12 * W + 3;
  localparam logic signed [2*W:0] BIAS = (2 * W + 1)'((64'd1 << F) - 64'd1);

  typedef logic signed [W-1:0] crd_t;

  function automatic crd_t sat(input logic [SATW-1:0] v);
    logic [SATW-W:0] top;
    top = v[SATW-1:W-1];
    if (&top || ~|top) return v[W-1:0];
    else if (v[SATW-1]) return {1'b1, {(W-1){1'b0}}};
    else return {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [2*W:0] mulq(input logic signed [2*W-1:0] p);
    logic signed [2*W:0] t;
    t = (2 * W + 1)'(p) + (p[2*W-1] ? BIAS : '0);
    return t >>> F;
  endfunction

  function automatic logic [W:0] absw1(input logic signed [W:0] v);
    return v[W] ? -v : v;
  endfunction

  function automatic logic signed [W:0] dif(input crd_t a, input crd_t b);
    return (W + 1)'(a) - (W + 1)'(b);
  endfunction

  function automatic logic btw(input crd_t v, input crd_t e0, input crd_t e1);
    return !((v >= e0 && v >= e1) || (v <= e0 && v <= e1));
  endfunction

  logic [MARGIN_W-1:0] margin;
  logic en;

  function automatic logic lt_marg(input logic [W:0] a, input logic [MARGIN_W-1:0] mg);
    return CMPW'(a) < CMPW'(mg);
  endfunction

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) margin <= MARGIN_RESET;
    else if (cfg_wen) margin <= cfg_wdata;
  end

  // stage 1: deltas and divider operands
  crd_t cin [8];
  logic [NW-1:0] n1_num [2];
  logic [DW-1:0] n1_den [2];
  logic          n1_neg [2];
  logic [1:0]    n1_vert, n1_ok;

  always_comb begin
    logic signed [W:0] dx;
    logic signed [W:0] dy;
    cin[0] = a_x0; cin[1] = a_y0; cin[2] = a_x1; cin[3] = a_y1;
    cin[4] = b_x0; cin[5] = b_y0; cin[6] = b_x1; cin[7] = b_y1;
    dx = '0;
    dy = '0;
    for (int l = 0; l < 2; l++) begin
      dx = dif(cin[4*l+2], cin[4*l]);
      dy = dif(cin[4*l+3], cin[4*l+1]);
      n1_vert[l] = dx == '0;
      n1_ok[l]   = dx != '0 || dy != '0;
      n1_num[l]  = NW'(absw1(dy)) << F;
      n1_den[l]  = absw1(dx);
      n1_neg[l]  = dx[W] ^ dy[W];
    end
  end

  logic          s1_v;
  crd_t          s1_c [8];
  logic [1:0]    s1_vert, s1_ok;
  logic [NW-1:0] s1_num [2];
  logic [DW-1:0] s1_den [2];
  logic          s1_neg [2];
  logic [SB1-1:0] sb1_in, sb1_out;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c    <= cin;
      s1_vert <= n1_vert;
      s1_ok   <= n1_ok;
      s1_num  <= n1_num;
      s1_den  <= n1_den;
      s1_neg  <= n1_neg;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) sb1_in[i*W +: W] = s1_c[i];
    sb1_in[8*W +: 2]   = s1_vert;
    sb1_in[8*W+2 +: 2] = s1_ok;
  end

  logic          d1_v;
  logic [NW-1:0] d1_q [2];
  logic          d1_neg [2];

  sgi_div #(.NW(NW), .DW(DW), .LANES(2), .SBW(SB1)) u_div_slope (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_v),
    .num       (s1_num),
    .den       (s1_den),
    .neg       (s1_neg),
    .in_sb     (sb1_in),
    .out_valid (d1_v),
    .quo       (d1_q),
    .out_neg   (d1_neg),
    .out_sb    (sb1_out)
  );

  // stage 2: signed, saturated slopes
  logic       s2_v;
  crd_t       s2_c [8];
  logic [1:0] s2_vert, s2_ok;
  crd_t       s2_m [2];
  crd_t       n2_m [2];

  always_comb begin
    logic signed [NW:0] qe;
    qe = '0;
    for (int l = 0; l < 2; l++) begin
      qe = d1_neg[l] ? -$signed({1'b0, d1_q[l]}) : $signed({1'b0, d1_q[l]});
      n2_m[l] = sb1_out[8*W+l] ? '0 : sat(SATW'(qe));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) s2_c[i] <= sb1_out[i*W +: W];
      s2_vert <= sb1_out[8*W +: 2];
      s2_ok   <= sb1_out[8*W+2 +: 2];
      s2_m    <= n2_m;
    end
  end

  // stage 3: m*x0 products
  logic                  s3_v;
  crd_t                  s3_c [8];
  logic [1:0]            s3_vert, s3_ok, s3_flat;
  crd_t                  s3_m [2];
  logic signed [2*W-1:0] s3_p [2];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c    <= s2_c;
      s3_vert <= s2_vert;
      s3_ok   <= s2_ok;
      s3_m    <= s2_m;
      for (int l = 0; l < 2; l++) begin
        s3_p[l]    <= (2 * W)'(s2_m[l]) * (2 * W)'(s2_c[4*l]);
        s3_flat[l] <= lt_marg(absw1((W + 1)'(s2_m[l])), margin);
      end
    end
  end

  // stage 4: intercepts
  logic       s4_v;
  crd_t       s4_c [8];
  logic [1:0] s4_vert, s4_ok;
  crd_t       s4_m [2];
  crd_t       s4_b [2];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c    <= s3_c;
      s4_vert <= s3_vert;
      s4_ok   <= s3_ok;
      s4_m    <= s3_m;
      for (int l = 0; l < 2; l++)
        s4_b[l] <= s3_flat[l] ? s3_c[4*l+1]
                 : sat(SATW'(s3_c[4*l+1]) - SATW'(mulq(s3_p[l])));
    end
  end

  // stage 5: parallel test and crossing divider operands
  logic          s5_v;
  crd_t          s5_c [8];
  logic [1:0]    s5_vert;
  crd_t          s5_m [2];
  crd_t          s5_b [2];
  logic          s5_cand;
  logic [NW-1:0] s5_num [1];
  logic [DW-1:0] s5_den [1];
  logic          s5_neg [1];
  logic [SB2-1:0] sb2_in, sb2_out;

  always_ff @(posedge clk) begin
    logic signed [W:0] dm;
    logic signed [W:0] db;
    logic              par;
    if (en) begin
      dm  = dif(s4_m[0], s4_m[1]);
      db  = dif(s4_b[1], s4_b[0]);
      par = (s4_vert == 2'b11) ||
            (s4_vert == 2'b00 && (lt_marg(absw1(dm), margin) || dm == '0));
      s5_c      <= s4_c;
      s5_vert   <= s4_vert;
      s5_m      <= s4_m;
      s5_b      <= s4_b;
      s5_cand   <= (s4_ok == 2'b11) && !par;
      s5_num[0] <= NW'(absw1(db)) << F;
      s5_den[0] <= absw1(dm);
      s5_neg[0] <= dm[W] ^ db[W];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) sb2_in[i*W +: W] = s5_c[i];
    for (int l = 0; l < 2; l++) begin
      sb2_in[8*W+l*W +: W]  = s5_m[l];
      sb2_in[10*W+l*W +: W] = s5_b[l];
    end
    sb2_in[12*W +: 2] = s5_vert;
    sb2_in[12*W+2]    = s5_cand;
  end

  logic          d2_v;
  logic [NW-1:0] d2_q [1];
  logic          d2_neg [1];

  sgi_div #(.NW(NW), .DW(DW), .LANES(1), .SBW(SB2)) u_div_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_v),
    .num       (s5_num),
    .den       (s5_den),
    .neg       (s5_neg),
    .in_sb     (sb2_in),
    .out_valid (d2_v),
    .quo       (d2_q),
    .out_neg   (d2_neg),
    .out_sb    (sb2_out)
  );

  // stage 6: crossing x
  logic       s6_v;
  crd_t       s6_c [8];
  logic [1:0] s6_vert;
  crd_t       s6_m [2];
  crd_t       s6_b [2];
  logic       s6_cand;
  crd_t       s6_px;

  always_ff @(posedge clk) begin
    logic signed [NW:0] qe;
    logic [1:0]         vt;
    if (en) begin
      qe = d2_neg[0] ? -$signed({1'b0, d2_q[0]}) : $signed({1'b0, d2_q[0]});
      vt = sb2_out[12*W +: 2];
      for (int i = 0; i < 8; i++) s6_c[i] <= sb2_out[i*W +: W];
      for (int l = 0; l < 2; l++) begin
        s6_m[l] <= sb2_out[8*W+l*W +: W];
        s6_b[l] <= sb2_out[10*W+l*W +: W];
      end
      s6_vert <= vt;
      s6_cand <= sb2_out[12*W+2];
      s6_px   <= vt[0] ? crd_t'(sb2_out[0 +: W])
               : vt[1] ? crd_t'(sb2_out[4*W +: W]) : sat(SATW'(qe));
    end
  end

  // stage 7: m*px products
  logic                  s7_v;
  crd_t                  s7_c [8];
  logic [1:0]            s7_vert;
  crd_t                  s7_b [2];
  logic                  s7_cand;
  crd_t                  s7_px;
  logic signed [2*W-1:0] s7_p [2];

  always_ff @(posedge clk) begin
    if (en) begin
      s7_c    <= s6_c;
      s7_vert <= s6_vert;
      s7_b    <= s6_b;
      s7_cand <= s6_cand;
      s7_px   <= s6_px;
      for (int l = 0; l < 2; l++) s7_p[l] <= (2 * W)'(s6_m[l]) * (2 * W)'(s6_px);
    end
  end

  // stage 8: line y at px, crossing y
  logic       s8_v;
  crd_t       s8_c [8];
  logic [1:0] s8_vert;
  logic       s8_cand;
  crd_t       s8_px, s8_py;
  crd_t       s8_ln [2];
  crd_t       n8_ln [2];

  always_comb begin
    for (int l = 0; l < 2; l++)
      n8_ln[l] = sat(SATW'(mulq(s7_p[l])) + SATW'(s7_b[l]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_c    <= s7_c;
      s8_vert <= s7_vert;
      s8_cand <= s7_cand;
      s8_px   <= s7_px;
      s8_ln   <= n8_ln;
      s8_py   <= s7_vert[0] ? n8_ln[1] : n8_ln[0];
    end
  end

  // stage 9: span checks, output register
  logic [1:0] on_seg;
  logic       hit_n;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (s8_vert[l])
        on_seg[l] = CMPW'(absw1(dif(s8_px, s8_c[4*l]))) <= CMPW'(margin) &&
                    btw(s8_py, s8_c[4*l+1], s8_c[4*l+3]);
      else
        on_seg[l] = btw(s8_px, s8_c[4*l], s8_c[4*l+2]) &&
                    CMPW'(absw1(dif(s8_py, s8_ln[l]))) <= CMPW'(margin);
    end
    hit_n = s8_cand && on_seg[0] && on_seg[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= hit_n;
      cross_x <= hit_n ? s8_px : '0;
      cross_y <= hit_n ? s8_py : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      s6_v      <= 1'b0;
      s7_v      <= 1'b0;
      s8_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= d1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      s6_v      <= d2_v;
      s7_v      <= s6_v;
      s8_v      <= s7_v;
      out_valid <= s8_v;
    end
  end

`ifndef SYNTH
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> cross_x == '0 && cross_y == '0)
    else $error("no-hit word carries a nonzero point");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output word is held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_v && !s8_v)
    else $error("pipeline not empty after reset");

  a_no_cand: assert property (@(posedge clk) disable iff (rst)
    s8_v && !s8_cand && en |=> out_valid && !hit)
    else $error("hit reported for parallel or degenerate pair");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import sgi_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 2 * (W + FB + 1) + 9;

  typedef logic signed [W-1:0] coord_t;

  typedef struct {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } pair_t;

  typedef struct {
    logic   hit;
    coord_t x;
    coord_t y;
  } cross_t;

  typedef struct {
    pair_t  w;
    bit     known;
    cross_t r;
  } row_t;

  typedef struct {
    longint x0, y0, x1, y1, m, b;
    bit     vert;
  } line_t;

  logic clk, rst;
  logic in_valid, in_stall;
  coord_t a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1;
  logic out_valid, out_stall, hit;
  coord_t cross_x, cross_y;
  logic cfg_wen;
  logic [MARGIN_W-1:0] cfg_wdata;

  logic [MARGIN_W-1:0] margin;
  cross_t pending[$];
  int errors;
  bit quiet;

  segment_intersection uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_x0(a_x0), .a_y0(a_y0), .a_x1(a_x1), .a_y1(a_y1),
    .b_x0(b_x0), .b_y0(b_y0), .b_x1(b_x1), .b_y1(b_y1),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .cross_x(cross_x), .cross_y(cross_y),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic longint sat(longint v);
    longint hi, lo;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b) / (longint'(1) << FB);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit make_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                   output line_t s);
    longint dx, dy;
    s.x0 = x0; s.y0 = y0; s.x1 = x1; s.y1 = y1;
    dx = s.x1 - s.x0;
    dy = s.y1 - s.y0;
    s.m = 0;
    s.b = 0;
    s.vert = (dx == 0);
    if (s.vert) return dy != 0;
    s.m = sat((dy * (longint'(1) << FB)) / dx);
    if (mag(s.m) < longint'(margin)) s.b = s.y0;
    else s.b = sat(s.y0 - fmul(s.m, s.x0));
    return 1;
  endfunction

  function automatic bit strictly_inside(longint v, longint e0, longint e1);
    if (v >= e0 && v >= e1) return 0;
    if (v <= e0 && v <= e1) return 0;
    return 1;
  endfunction

  function automatic bit lies_on(line_t s, longint px, longint py);
    if (s.vert) begin
      if (mag(px - s.x0) > longint'(margin)) return 0;
      return strictly_inside(py, s.y0, s.y1);
    end
    if (!strictly_inside(px, s.x0, s.x1)) return 0;
    return mag(py - sat(fmul(s.m, px) + s.b)) <= longint'(margin);
  endfunction

  function automatic cross_t crossing(pair_t w);
    line_t la, lb;
    bit ok_a, ok_b, par, h;
    longint dm, px, py;
    cross_t r;
    ok_a = make_line(w.ax0, w.ay0, w.ax1, w.ay1, la);
    ok_b = make_line(w.bx0, w.by0, w.bx1, w.by1, lb);
    h = 0; px = 0; py = 0;
    if (ok_a && ok_b) begin
      dm = la.m - lb.m;
      par = (la.vert && lb.vert) ||
            (!la.vert && !lb.vert && (mag(dm) < longint'(margin) || dm == 0));
      if (!par) begin
        if (la.vert) begin
          px = la.x0;
          py = sat(fmul(lb.m, px) + lb.b);
        end else if (lb.vert) begin
          px = lb.x0;
          py = sat(fmul(la.m, px) + la.b);
        end else begin
          px = sat(((lb.b - la.b) * (longint'(1) << FB)) / dm);
          py = sat(fmul(la.m, px) + la.b);
        end
        h = lies_on(la, px, py) && lies_on(lb, px, py);
      end
    end
    r.hit = h;
    r.x = h ? coord_t'(px) : '0;
    r.y = h ? coord_t'(py) : '0;
    return r;
  endfunction

  task automatic send(pair_t w, bit known, cross_t r);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    a_x0 <= w.ax0; a_y0 <= w.ay0; a_x1 <= w.ax1; a_y1 <= w.ay1;
    b_x0 <= w.bx0; b_y0 <= w.by0; b_x1 <= w.bx1; b_y1 <= w.by1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(known ? r : crossing(w));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_margin(logic [MARGIN_W-1:0] v);
    drain();
    cfg_wen <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 0;
    margin = v;
  endtask

  function automatic coord_t near(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic pair_t random_pair();
    pair_t w;
    int k, span;
    k = $urandom_range(0, 9);
    span = (k < 5 && $urandom_range(0, 1)) ? 32'h0004_0000 : 32'h0100_0000;
    w.ax0 = near(span); w.ay0 = near(span); w.ax1 = near(span); w.ay1 = near(span);
    w.bx0 = near(span); w.by0 = near(span); w.bx1 = near(span); w.by1 = near(span);
    case (k)
      0, 1: begin
        w.ax0 = $urandom; w.ay0 = $urandom; w.ax1 = $urandom; w.ay1 = $urandom;
        w.bx0 = $urandom; w.by0 = $urandom; w.bx1 = $urandom; w.by1 = $urandom;
      end
      7: begin
        if ($urandom_range(0, 1)) w.ax1 = w.ax0;
        else w.bx1 = w.bx0;
      end
      8: begin
        w.bx0 = w.ax0 + near(span / 4); w.by0 = w.ay0 + near(span / 4);
        w.bx1 = w.bx0 + (w.ax1 - w.ax0);
        w.by1 = w.by0 + (w.ay1 - w.ay0) + near(2);
      end
      9: begin
        if ($urandom_range(0, 1)) begin
          w.bx1 = w.bx0; w.by1 = w.by0;
        end else begin
          w.by0 = w.ay0; w.by1 = w.ay1;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  localparam coord_t ONE = 32'sh0001_0000;
  localparam coord_t TWO = 32'sh0002_0000;
  localparam coord_t THREE = 32'sh0003_0000;
  localparam coord_t MAXC = 32'sh7fff_ffff;
  localparam coord_t MINC = 32'sh8000_0000;
  localparam cross_t MISS = '{1'b0, '0, '0};

  row_t rows[] = '{
    '{'{0, 0, TWO, TWO, 0, TWO, TWO, 0}, 1, '{1'b1, ONE, ONE}},
    '{'{0, 0, 0, 0, 0, TWO, TWO, 0}, 1, MISS},
    '{'{0, 0, TWO, TWO, ONE, ONE, ONE, ONE}, 1, MISS},
    '{'{0, 0, 0, TWO, ONE, 0, ONE, TWO}, 1, MISS},
    '{'{ONE, 0, ONE, TWO, 0, ONE, TWO, ONE}, 1, '{1'b1, ONE, ONE}},
    '{'{0, ONE, TWO, ONE, ONE, 0, ONE, TWO}, 1, '{1'b1, ONE, ONE}},
    '{'{0, 0, TWO, TWO, 0, ONE, TWO, THREE}, 1, MISS},
    '{'{0, 0, ONE, ONE, ONE, ONE, TWO, 0}, 1, MISS},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1, MISS},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 1, MISS},
    '{'{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC}, 1, '{1'b1, 0, 0}},
    '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 0, MISS},
    '{'{0, 0, 1, MAXC, MINC, ONE, MAXC, 0}, 0, MISS},
    '{'{0, MINC, 1, MAXC, MINC, 0, MAXC, 1}, 0, MISS},
    '{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
        32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555}, 0, MISS},
    '{'{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC}, 0, MISS}
  };

  initial begin
    logic [MARGIN_W-1:0] settings[6];
    rst = 1; in_valid = 0; cfg_wen = 0; cfg_wdata = '0; out_stall = 0;
    a_x0 = 0; a_y0 = 0; a_x1 = 0; a_y1 = 0;
    b_x0 = 0; b_y0 = 0; b_x1 = 0; b_y1 = 0;
    errors = 0; quiet = 0; margin = MARGIN_RESET;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].w, rows[i].known, rows[i].r);
    settings = '{MARGIN_RESET, '0, 17'h10000, 17'h1ffff,
                 MARGIN_W'($urandom_range(2, 4096)), MARGIN_W'($urandom)};
    foreach (settings[p]) begin
      if (p > 0) set_margin(settings[p]);
      else drain();
      if (p == 0) begin
        send(rows[0].w, 0, MISS);
        send(rows[6].w, 0, MISS);
      end
      quiet = (p == 2);
      repeat (250) send(random_pair(), 0, MISS);
      quiet = 0;
    end
    drain();
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && !rst && $urandom_range(0, 99) < 7;
  end

  always @(posedge clk) begin
    cross_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected word hit=%b x=%h y=%h", $time, hit, cross_x, cross_y);
        errors++;
      end else begin
        e = pending.pop_front();
        if (hit !== e.hit) begin
          $display("%0t: hit expected %b actual %b", $time, e.hit, hit);
          errors++;
        end
        if (cross_x !== e.x) begin
          $display("%0t: cross_x expected %h actual %h", $time, e.x, cross_x);
          errors++;
        end
        if (cross_y !== e.y) begin
          $display("%0t: cross_y expected %h actual %h", $time, e.y, cross_y);
          errors++;
        end
      end
    end
  end

endmodule
